// File: rtl/qst_pkg.sv
`timescale 1ns / 1ps
package qst_pkg;

  typedef enum logic [1:0] {
    KIND_KEY        = 2'd0,
    KIND_VALUE      = 2'd1,
    KIND_PAIR_END   = 2'd2,
    KIND_STRING_END = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DEC_WAIT = 2'd0,
    DEC_SEP  = 2'd1,
    DEC_EQ   = 2'd2,
    DEC_BYTE = 2'd3
  } dec_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      item_kind;
  } out_item_t;

  // Patterns as seen by the classifier; lengths are already clamped.
  typedef struct packed {
    logic [31:0] sep_bytes;
    logic [2:0]  sep_len;
    logic [31:0] eq_bytes;
    logic [2:0]  eq_len;
  } match_cfg_t;

  localparam logic [2:0] REG_SEP_BYTES  = 3'd0;
  localparam logic [2:0] REG_SEP_LENGTH = 3'd1;
  localparam logic [2:0] REG_EQ_BYTES   = 3'd2;
  localparam logic [2:0] REG_EQ_LENGTH  = 3'd3;
  localparam logic [2:0] REG_PART_LIMIT = 3'd4;

  localparam logic [31:0] SEP_BYTES_RESET  = 32'h0000_0026;
  localparam logic [2:0]  SEP_LENGTH_RESET = 3'd1;
  localparam logic [31:0] EQ_BYTES_RESET   = 32'h0000_003D;
  localparam logic [2:0]  EQ_LENGTH_RESET  = 3'd1;
  localparam logic [15:0] PART_LIMIT_RESET = 16'd1000;

endpackage

// File: rtl/qst_stream_if.sv
`timescale 1ns / 1ps
interface qst_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/qst_classify.sv
`timescale 1ns / 1ps
module qst_classify
  import qst_pkg::*;
#(
  parameter int WIN_DEPTH = 8
) (
  input  logic [WIN_DEPTH-1:0][7:0]     win,
  input  logic [$clog2(WIN_DEPTH+1)-1:0] count,
  input  match_cfg_t                    cfg,
  input  logic                          flush,
  input  logic                          value_part,
  output dec_t                          dec
);

  localparam int CAP = (WIN_DEPTH / 2 < 4) ? WIN_DEPTH / 2 : 4;
  localparam int CW  = $clog2(WIN_DEPTH + 1);
  localparam int PW  = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  typedef enum logic [1:0] {
    MATCH_NONE = 2'd0,
    MATCH_PART = 2'd1,
    MATCH_FULL = 2'd2
  } match_t;

  // Missing bytes always form a tail of the pattern, so a mismatch among the
  // bytes present decides the result regardless of what is still to come.
  function automatic match_t match_at(input logic [WIN_DEPTH-1:0][7:0] w,
                                      input logic [CW-1:0] n,
                                      input logic [31:0] pat,
                                      input logic [2:0] len,
                                      input int off,
                                      input logic fl);
    logic mism;
    logic miss;
    int   pos;
    mism = 1'b0;
    miss = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      pos = off + i;
      if (3'(i) < len) begin
        if (pos >= int'(n)) begin
          miss = 1'b1;
        end else if (w[pos[PW-1:0]] != pat[8*i +: 8]) begin
          mism = 1'b1;
        end
      end
    end
    if (mism) return MATCH_NONE;
    if (miss) return fl ? MATCH_NONE : MATCH_PART;
    return MATCH_FULL;
  endfunction

  match_t sep_head;
  match_t eq_head;
  logic   sep_inside_full;
  logic   sep_inside_part;

  always_comb begin
    match_t t;
    sep_head = match_at(win, count, cfg.sep_bytes, cfg.sep_len, 0, flush);
    eq_head  = match_at(win, count, cfg.eq_bytes, cfg.eq_len, 0, flush);
    sep_inside_full = 1'b0;
    sep_inside_part = 1'b0;
    // A separator that starts inside the divider occurrence wins over it.
    for (int k = 1; k < CAP; k++) begin
      t = match_at(win, count, cfg.sep_bytes, cfg.sep_len, k, flush);
      if (3'(k) < cfg.eq_len) begin
        if (t == MATCH_FULL) sep_inside_full = 1'b1;
        if (t == MATCH_PART) sep_inside_part = 1'b1;
      end
    end
  end

  always_comb begin
    if (sep_head == MATCH_FULL) begin
      dec = DEC_SEP;
    end else if (sep_head == MATCH_PART) begin
      dec = DEC_WAIT;
    end else if (value_part) begin
      dec = DEC_BYTE;
    end else if (eq_head == MATCH_PART) begin
      dec = DEC_WAIT;
    end else if (eq_head == MATCH_NONE) begin
      dec = DEC_BYTE;
    end else if (sep_inside_full) begin
      dec = DEC_BYTE;
    end else if (sep_inside_part) begin
      dec = DEC_WAIT;
    end else begin
      dec = DEC_EQ;
    end
  end

endmodule

// File: rtl/query_string_tokenizer_core.sv
`timescale 1ns / 1ps
// Query string tokenizer. Bytes of a query string arrive on the raw channel,
// one per transfer, with in_last on the final byte. Tagged items leave on the
// token channel: key bytes, value bytes, a pair end after each non-empty part
// and a string end after the final byte. Separator, divider and part limit
// are set through the APB port, which must be written only while the block is
// idle; the block itself does not enforce this. A write abandons any string in
// progress. Incoming bytes go into a window of 2*MATCH_MAX bytes. One decision
// a cycle is taken on the oldest byte (content, divider or separator) while the
// token slot is free and no partial match makes it wait, so the sustained rate
// is one byte per cycle; a transferred byte passes through the window register
// and then the token output register. After a final byte the raw channel pauses
// while the rest of the window is decided, one decision a cycle, and while the
// pair end and string end items are issued.
// Reset loads the default registers (ampersand, equals sign, 1000 parts) and
// clears all per-string state. When the receiver stalls, the output register
// holds its item and decisions stop; the window keeps taking bytes until it is
// full, then raw.ready drops.
module query_string_tokenizer_core
  import qst_pkg::*;
#(
  parameter int MATCH_MAX = 4
) (
  input  logic        clk,
  input  logic        rst,
  qst_stream_if.sink   raw,
  qst_stream_if.source token,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CAP = (MATCH_MAX < 4) ? MATCH_MAX : 4;
  localparam int WIN = 2 * MATCH_MAX;
  localparam int CW  = $clog2(WIN + 1);
  localparam int PW  = (WIN > 1) ? $clog2(WIN) : 1;

  function automatic logic [2:0] eff_len(input logic [2:0] len);
    if (len == 3'd0) return 3'd1;
    if (len > 3'(CAP)) return 3'(CAP);
    return len;
  endfunction

  // Configuration registers
  logic [31:0] sep_bytes;
  logic [2:0]  sep_length;
  logic [31:0] eq_bytes;
  logic [2:0]  eq_length;
  logic [15:0] part_limit;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       cfg_hit;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_SEP_BYTES, REG_SEP_LENGTH, REG_EQ_BYTES, REG_EQ_LENGTH,
      REG_PART_LIMIT: cfg_hit = cfg_wr;
      default:        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_bytes  <= SEP_BYTES_RESET;
      sep_length <= SEP_LENGTH_RESET;
      eq_bytes   <= EQ_BYTES_RESET;
      eq_length  <= EQ_LENGTH_RESET;
      part_limit <= PART_LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SEP_BYTES:  sep_bytes  <= pwdata;
        REG_SEP_LENGTH: sep_length <= pwdata[2:0];
        REG_EQ_BYTES:   eq_bytes   <= pwdata;
        REG_EQ_LENGTH:  eq_length  <= pwdata[2:0];
        REG_PART_LIMIT: part_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SEP_BYTES:  prdata = sep_bytes;
      REG_SEP_LENGTH: prdata = {29'd0, sep_length};
      REG_EQ_BYTES:   prdata = eq_bytes;
      REG_EQ_LENGTH:  prdata = {29'd0, eq_length};
      REG_PART_LIMIT: prdata = {16'd0, part_limit};
      default:        prdata = 32'd0;
    endcase
  end

  // Per-string state
  logic [WIN-1:0][7:0] win;
  logic [CW-1:0]       cnt;
  logic                value_part;
  logic                part_nonempty;
  logic                part_begun;
  logic [15:0]         parts_seen;
  logic                limit_reached;
  logic                flush_pending;
  logic                tok_valid;
  out_item_t           tok_item;

  logic [WIN-1:0][7:0] win_next;
  logic [CW-1:0]       cnt_next;
  logic                value_part_next;
  logic                part_nonempty_next;
  logic                part_begun_next;
  logic [15:0]         parts_seen_next;
  logic                limit_reached_next;
  logic                flush_pending_next;

  match_cfg_t match_cfg;
  dec_t       dec;
  logic [2:0] sep_eff;
  logic [2:0] eq_eff;

  assign sep_eff             = eff_len(sep_length);
  assign eq_eff              = eff_len(eq_length);
  assign match_cfg.sep_bytes = sep_bytes;
  assign match_cfg.sep_len   = sep_eff;
  assign match_cfg.eq_bytes  = eq_bytes;
  assign match_cfg.eq_len    = eq_eff;

  qst_classify #(
    .WIN_DEPTH(WIN)
  ) u_classify (
    .win       (win),
    .count     (cnt),
    .cfg       (match_cfg),
    .flush     (flush_pending),
    .value_part(value_part),
    .dec       (dec)
  );

  logic      slot_free;
  logic      raw_fire;
  logic      active;
  logic      begin_now;
  logic      limit_hit;
  logic      decide;
  logic      finish;
  logic      restart;
  logic      append;
  logic      emit;
  out_item_t emit_item;
  logic [2:0]    drop;
  logic [CW-1:0] kept;

  assign slot_free   = !tok_valid || token.ready;
  assign raw.ready   = !flush_pending && (cnt < CW'(WIN));
  assign raw_fire    = raw.valid && raw.ready;
  assign token.valid = tok_valid;
  assign token.data  = tok_item;

  assign active    = slot_free && (cnt != '0) && !limit_reached;
  assign begin_now = active && !part_begun;
  assign limit_hit = begin_now && (part_limit != 16'd0) && (parts_seen >= part_limit);
  assign decide    = active && !limit_hit && (dec != DEC_WAIT);
  assign finish    = slot_free && flush_pending && (cnt == '0);

  always_comb begin
    value_part_next    = value_part;
    part_nonempty_next = part_nonempty;
    part_begun_next    = part_begun;
    parts_seen_next    = parts_seen;
    limit_reached_next = limit_reached;
    flush_pending_next = flush_pending;
    emit               = 1'b0;
    emit_item          = '{out_byte: 8'd0, item_kind: KIND_KEY};
    drop               = 3'd0;
    restart            = cfg_hit;

    // Counting a new part comes before the decision on its first byte.
    if (begin_now && !limit_hit) begin
      part_begun_next = 1'b1;
      if (parts_seen != 16'hFFFF) parts_seen_next = parts_seen + 16'd1;
    end
    if (limit_hit) limit_reached_next = 1'b1;

    if (decide) begin
      unique case (dec)
        DEC_SEP: begin
          if (part_nonempty) begin
            emit      = 1'b1;
            emit_item = '{out_byte: 8'd0, item_kind: KIND_PAIR_END};
          end
          drop               = sep_eff;
          value_part_next    = 1'b0;
          part_nonempty_next = 1'b0;
          part_begun_next    = 1'b0;
        end
        DEC_EQ: begin
          drop               = eq_eff;
          value_part_next    = 1'b1;
          part_nonempty_next = 1'b1;
        end
        DEC_BYTE: begin
          emit               = 1'b1;
          emit_item          = '{out_byte: win[0],
                                 item_kind: value_part ? KIND_VALUE : KIND_KEY};
          drop               = 3'd1;
          part_nonempty_next = 1'b1;
        end
        default: ;
      endcase
    end

    // End of string: the open pair is closed first, then the string end.
    if (finish) begin
      emit = 1'b1;
      if (part_nonempty && !limit_reached) begin
        emit_item          = '{out_byte: 8'd0, item_kind: KIND_PAIR_END};
        part_nonempty_next = 1'b0;
      end else begin
        emit_item = '{out_byte: 8'd0, item_kind: KIND_STRING_END};
        restart   = 1'b1;
      end
    end

    if (raw_fire && raw.data.in_last) flush_pending_next = 1'b1;

    if (restart) begin
      value_part_next    = 1'b0;
      part_nonempty_next = 1'b0;
      part_begun_next    = 1'b0;
      parts_seen_next    = 16'd0;
      limit_reached_next = 1'b0;
      flush_pending_next = 1'b0;
    end
  end

  // Bytes that arrive once the limit has stopped the string are discarded.
  assign append = raw_fire && !limit_reached && !limit_hit && !restart;
  assign kept   = (restart || limit_hit) ? '0 : cnt - CW'(drop);

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      if (append && (kept == CW'(j))) begin
        win_next[j] = raw.data.in_byte;
      end else if (j + int'(drop) < WIN) begin
        win_next[j] = win[PW'(j + int'(drop))];
      end else begin
        win_next[j] = win[j];
      end
    end
    cnt_next = kept + CW'(append);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      value_part    <= 1'b0;
      part_nonempty <= 1'b0;
      part_begun    <= 1'b0;
      parts_seen    <= 16'd0;
      limit_reached <= 1'b0;
      flush_pending <= 1'b0;
      tok_valid     <= 1'b0;
    end else begin
      cnt           <= cnt_next;
      value_part    <= value_part_next;
      part_nonempty <= part_nonempty_next;
      part_begun    <= part_begun_next;
      parts_seen    <= parts_seen_next;
      limit_reached <= limit_reached_next;
      flush_pending <= flush_pending_next;
      if (slot_free) tok_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    if (slot_free) tok_item <= emit_item;
  end

endmodule

// File: rtl/qst_checker.sv
`timescale 1ns / 1ps
module qst_checker
  import qst_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       raw_valid,
  input logic       raw_ready,
  input logic       raw_last,
  input logic       tok_valid,
  input logic       tok_ready,
  input logic [7:0] tok_byte,
  input kind_t      tok_kind,
  input logic       cfg_write
);

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !tok_valid)
    else $error("token valid after reset");

  a_stalled_item_holds: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok_byte) && $stable(tok_kind))
    else $error("stalled token item changed");

  // The next string may not start until the current one has been closed.
  a_final_byte_blocks: assert property (@(posedge clk) disable iff (rst)
    raw_valid && raw_ready && raw_last && !cfg_write |=> !raw_ready)
    else $error("raw channel open right after a final byte");

  a_marker_byte_zero: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok_kind == KIND_PAIR_END || tok_kind == KIND_STRING_END)
    |-> tok_byte == 8'd0)
    else $error("marker item carries a nonzero byte");

endmodule

bind query_string_tokenizer_core qst_checker u_qst_checker (
  .clk      (clk),
  .rst      (rst),
  .raw_valid(raw.valid),
  .raw_ready(raw.ready),
  .raw_last (raw.data.in_last),
  .tok_valid(token.valid),
  .tok_ready(token.ready),
  .tok_byte (token.data.out_byte),
  .tok_kind (token.data.item_kind),
  .cfg_write(psel && penable && pwrite)
);

// File: tb/query_string_tokenizer_core_test.sv
`timescale 1ns / 1ps
module query_string_tokenizer_core_test;
  import qst_pkg::*;

  localparam int MATCH_MAX = 4;
  localparam int WINDOW = 2 * MATCH_MAX - 1;
  localparam int MAX_TOKENS_PER_BYTE = 7;
  localparam int SETTLE_CYCLES = 2 * MATCH_MAX + 4;
  localparam int END_CYCLES = 4 * MATCH_MAX + 8;
  localparam int HOLD_CYCLES = 60;
  localparam int LIMIT_CYCLES = 400000;

  typedef enum int {NO_MATCH, PART_MATCH, FULL_MATCH} match_t;

  class token_checker;
    logic [31:0] sep_bytes;
    logic [2:0]  sep_len;
    logic [31:0] eq_bytes;
    logic [2:0]  eq_len;
    logic [15:0] part_limit;

    logic [7:0]  held [WINDOW];
    int          held_n;
    bit          in_value;
    bit          nonempty;
    bit          begun;
    bit          limit_hit;
    logic [15:0] parts_seen;

    out_item_t   pending_tokens[$];
    int          step_tokens;
    int          tokens_checked;
    int          failures;

    function new();
      sep_bytes = SEP_BYTES_RESET;
      sep_len = SEP_LENGTH_RESET;
      eq_bytes = EQ_BYTES_RESET;
      eq_len = EQ_LENGTH_RESET;
      part_limit = PART_LIMIT_RESET;
      tokens_checked = 0;
      failures = 0;
      clear_string();
    endfunction

    function void clear_string();
      held_n = 0;
      in_value = 0;
      nonempty = 0;
      begun = 0;
      limit_hit = 0;
      parts_seen = '0;
    endfunction

    function int eff_len(logic [2:0] len);
      if (len == 0) return 1;
      return (len > MATCH_MAX) ? MATCH_MAX : int'(len);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_SEP_BYTES:  sep_bytes = value;
        REG_SEP_LENGTH: sep_len = value[2:0];
        REG_EQ_BYTES:   eq_bytes = value;
        REG_EQ_LENGTH:  eq_len = value[2:0];
        REG_PART_LIMIT: part_limit = value[15:0];
        default: return;
      endcase
      clear_string();
    endfunction

    function match_t match_at(logic [31:0] pat, int plen, int off, bit flush);
      int pos;
      for (int i = 0; i < plen; i++) begin
        pos = off + i;
        if (pos >= held_n || pos >= WINDOW) return flush ? NO_MATCH : PART_MATCH;
        if (held[pos] != pat[8*i +: 8]) return NO_MATCH;
      end
      return FULL_MATCH;
    endfunction

    // A divider only wins if no separator begins inside it; while one might,
    // the decision waits for more bytes.
    function dec_t classify(bit flush);
      int sl;
      int el;
      match_t s;
      match_t e;
      match_t t;
      bit undecided;
      sl = eff_len(sep_len);
      el = eff_len(eq_len);
      undecided = 0;
      s = match_at(sep_bytes, sl, 0, flush);
      if (s == FULL_MATCH) return DEC_SEP;
      if (s == PART_MATCH) return DEC_WAIT;
      if (in_value) return DEC_BYTE;
      e = match_at(eq_bytes, el, 0, flush);
      if (e == PART_MATCH) return DEC_WAIT;
      if (e == NO_MATCH) return DEC_BYTE;
      for (int k = 1; k < el; k++) begin
        t = match_at(sep_bytes, sl, k, flush);
        if (t == FULL_MATCH) return DEC_BYTE;
        if (t == PART_MATCH) undecided = 1;
      end
      return undecided ? DEC_WAIT : DEC_EQ;
    endfunction

    function void push_token(logic [7:0] b, kind_t kind);
      out_item_t tok;
      if (step_tokens < MAX_TOKENS_PER_BYTE) begin
        tok.out_byte = b;
        tok.item_kind = kind;
        pending_tokens.push_back(tok);
        step_tokens++;
      end
    endfunction

    function void drop_front(int k);
      if (k > held_n) k = held_n;
      for (int i = 0; i < held_n - k; i++) held[i] = held[i + k];
      held_n -= k;
    endfunction

    // Called for every accepted byte transfer.
    function void note_byte(logic [7:0] b, logic last);
      dec_t d;
      step_tokens = 0;
      if (!limit_hit && held_n < WINDOW) begin
        held[held_n] = b;
        held_n++;
      end
      while (held_n > 0 && !limit_hit) begin
        if (!begun) begin
          if (part_limit != 0 && parts_seen >= part_limit) begin
            limit_hit = 1;
            held_n = 0;
            break;
          end
          if (parts_seen != 16'hFFFF) parts_seen++;
          begun = 1;
        end
        d = classify(last);
        if (d == DEC_WAIT) break;
        case (d)
          DEC_SEP: begin
            if (nonempty) push_token(8'h00, KIND_PAIR_END);
            drop_front(eff_len(sep_len));
            in_value = 0;
            nonempty = 0;
            begun = 0;
          end
          DEC_EQ: begin
            drop_front(eff_len(eq_len));
            in_value = 1;
            nonempty = 1;
          end
          default: begin
            push_token(held[0], in_value ? KIND_VALUE : KIND_KEY);
            nonempty = 1;
            drop_front(1);
          end
        endcase
      end
      if (last) begin
        if (!limit_hit && nonempty) push_token(8'h00, KIND_PAIR_END);
        push_token(8'h00, KIND_STRING_END);
        clear_string();
      end
    endfunction

    function void check_token(out_item_t got);
      out_item_t want;
      if (pending_tokens.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected token: byte %h kind %0d with nothing outstanding",
                   got.out_byte, got.item_kind);
        return;
      end
      want = pending_tokens.pop_front();
      if (got.out_byte !== want.out_byte || got.item_kind !== want.item_kind) begin
        failures++;
        if (failures <= 10)
          $display("Token %0d: expected byte %h kind %0d, got byte %h kind %0d",
                   tokens_checked, want.out_byte, want.item_kind,
                   got.out_byte, got.item_kind);
      end
      tokens_checked++;
    endfunction

    function int waiting();
      return pending_tokens.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  qst_stream_if #(.item_t(in_item_t))  raw_if ();
  qst_stream_if #(.item_t(out_item_t)) token_if ();

  query_string_tokenizer_core DUT (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw_if),
    .token   (token_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  token_checker sb;
  logic [7:0]   text_q[$];
  int           idle_pct;
  int           stall_pct;
  int           hold_asked;
  int           hold_done;
  int           hold_left;
  int           cycle_count = 0;
  int           bytes_sent;
  int           strings_sent;
  int           writes_done;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver pacing, including the long hold-off that lets the window fill.
  initial begin
    token_if.ready = 1'b0;
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        token_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        token_if.ready <= 1'b0;
        hold_left--;
      end else begin
        token_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && token_if.valid && token_if.ready) sb.check_token(token_if.data);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    raw_if.valid <= 1'b1;
    raw_if.data <= '{in_byte: b, in_last: last};
    do @(posedge clk); while (!raw_if.ready);
    sb.note_byte(b, last);
    bytes_sent++;
    if (last) strings_sent++;
    if ($urandom_range(99) < idle_pct) begin
      raw_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_text(input bit finish);
    foreach (text_q[i]) send_byte(text_q[i], finish && i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void load_text(input string str);
    for (int i = 0; i < str.len(); i++) text_q.push_back(str[i]);
  endfunction

  function automatic void add_pattern(input logic [31:0] pat, input logic [2:0] len);
    for (int i = 0; i < sb.eff_len(len); i++) text_q.push_back(pat[8*i +: 8]);
  endfunction

  // Biased towards pattern bytes so that partial and overlapping matches occur.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0, 1, 2: return sb.sep_bytes[8*$urandom_range(3) +: 8];
      3, 4:    return sb.eq_bytes[8*$urandom_range(3) +: 8];
      5:       return 8'h61 + 8'($urandom_range(1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_strings(input int target);
    int parts;
    int sent;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 8)) text_q.push_back(pick_byte());
      end else begin
        parts = $urandom_range(1, 4);
        for (int p = 0; p < parts; p++) begin
          if (p > 0) add_pattern(sb.sep_bytes, sb.sep_len);
          if ($urandom_range(7) != 0) begin
            repeat ($urandom_range(0, 3)) text_q.push_back(pick_byte());
            if ($urandom_range(3) != 0) add_pattern(sb.eq_bytes, sb.eq_len);
            repeat ($urandom_range(0, 3)) text_q.push_back(pick_byte());
          end
        end
        if ($urandom_range(5) == 0) add_pattern(sb.sep_bytes, sb.sep_len);
      end
      if (text_q.size() == 0) text_q.push_back(pick_byte());
      sent += text_q.size();
      send_text(1'b1);
    end
  endtask

  task automatic drain();
    raw_if.valid <= 1'b0;
    do @(posedge clk); while (sb.waiting() != 0);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    writes_done++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] sep_b, input logic [2:0] sep_l,
                           input logic [31:0] eq_b, input logic [2:0] eq_l,
                           input logic [15:0] limit);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_SEP_BYTES, sep_b);
    apb_write(REG_SEP_LENGTH, 32'(sep_l));
    apb_write(REG_EQ_BYTES, eq_b);
    apb_write(REG_EQ_LENGTH, 32'(eq_l));
    apb_write(REG_PART_LIMIT, 32'(limit));
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    raw_if.valid = 1'b0;
    raw_if.data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_asked = 0;
    bytes_sent = 0;
    strings_sent = 0;
    writes_done = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Key and value, a part that is only a divider, and a part with no divider.
    load_text("k=v&=&x");
    send_text(1'b1);
    // Empty parts, the extreme byte values and a trailing separator.
    load_text("&&");
    text_q.push_back(8'hFF);
    load_text("=");
    text_q.push_back(8'h00);
    load_text("&");
    send_text(1'b1);
    // A second divider inside the value is plain content.
    load_text("a=b=c");
    send_text(1'b1);
    configure(SEP_BYTES_RESET, SEP_LENGTH_RESET, EQ_BYTES_RESET, EQ_LENGTH_RESET, 16'd1);
    load_text("a&b");
    send_text(1'b1);
    // An empty part still counts towards the limit, so the rest is dropped.
    load_text("&ab");
    send_text(1'b1);

    configure(32'h0000_0026, 3'd1, 32'h0000_003D, 3'd1, 16'd0);
    send_random_strings(12);

    configure(32'h0000_2626, 3'd2, 32'h003D_3D3D, 3'd3, 16'd3);
    idle_pct = 84;
    send_random_strings(12);

    configure(32'h6261_6261, 3'd4, 32'h0062_6161, 3'd4, 16'hFFFF);
    idle_pct = 0;
    stall_pct = 84;
    send_random_strings(12);
    // Leave a string unfinished; the next register write abandons it.
    load_text("ab");
    send_text(1'b0);

    // Length zero acts as one and lengths above four are saturated to four.
    configure(32'hFFFF_FFFF, 3'd0, 32'h0000_0000, 3'd7, 16'd2);
    idle_pct = 36;
    stall_pct = 36;
    send_random_strings(12);

    configure(32'h2F3D_2F3D, 3'd5, 32'h0000_003D, 3'd0, 16'd0);
    send_random_strings(8);
    // Hold the receiver off while the sender keeps offering transfers; the
    // first string is long enough to fill the window.
    idle_pct = 0;
    hold_asked++;
    load_text("key1=value1=/=/k2=v2");
    send_text(1'b1);
    send_random_strings(8);
    idle_pct = 36;
    drain();
    send_random_strings(8);

    configure(32'h0000_3D3D, 3'd2, 32'h0000_003D, 3'd1, 16'hFFFF);
    idle_pct = 0;
    stall_pct = 0;
    send_random_strings(12);

    drain();
    repeat (END_CYCLES) @(posedge clk);
    sb.failures += sb.waiting();
    $display("Covered %0d bytes in %0d strings, %0d tokens checked, %0d register writes.",
             bytes_sent, strings_sent, sb.tokens_checked, writes_done);
    $display("Pacing ran free, with sender gaps, receiver stalls, both, and a long hold-off.");
    if (sb.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
